// ===== rtl/core/bmsi_pkg.sv =====
// ----------------------------------------------------------------------------
// bmsi_pkg
// Types and constants shared by the bank mapper with scanline interrupt.
// ----------------------------------------------------------------------------
package bmsi_pkg;

	// request type codes
	localparam logic [2:0] REQ_CPU_RD = 3'd0;
	localparam logic [2:0] REQ_CPU_WR = 3'd1;
	localparam logic [2:0] REQ_PPU_RD = 3'd2;
	localparam logic [2:0] REQ_PPU_WR = 3'd3;
	localparam logic [2:0] REQ_A12    = 3'd4;

	// result target codes
	localparam logic [1:0] TGT_NONE    = 2'd0;
	localparam logic [1:0] TGT_PRG_ROM = 2'd1;
	localparam logic [1:0] TGT_PRG_RAM = 2'd2;
	localparam logic [1:0] TGT_CHR     = 2'd3;

	// mirroring codes
	localparam logic [1:0] MIRROR_VERT = 2'd0;
	localparam logic [1:0] MIRROR_HORZ = 2'd1;
	localparam logic [1:0] MIRROR_FOUR = 2'd2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANKS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANKS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_MIRROR = 3'd4;

	// bank count limits
	localparam int MAX_PRG_BANKS = 64;
	localparam int MAX_CHR_BANKS = 256;
	localparam int MIN_PRG_BANKS = 2;
	localparam int MIN_CHR_BANKS = 8;

	// cpu address map
	localparam logic [15:0] ADDR_RAM_BASE = 16'h6000;

	// mapper register groups, selected by address bits 14:13
	localparam logic [1:0] REG_BANK   = 2'd0;
	localparam logic [1:0] REG_MIRROR = 2'd1;
	localparam logic [1:0] REG_LATCH  = 2'd2;
	localparam logic [1:0] REG_IRQ    = 2'd3;

	// request queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// modulo unit: one restoring step per bank number bit
	localparam int DIV_STEPS = 8;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// classified operation
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PRG,
		OP_RAM,
		OP_REG,
		OP_CHR,
		OP_A12
	} op_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] address;
		logic [7:0]  write_data;
	} item_t;

	typedef struct packed {
		logic [1:0]  target;
		logic [18:0] mem_address;
		logic        mem_write;
		logic        irq;
		logic [1:0]  mirror_mode;
	} result_t;

	typedef struct packed {
		op_t         op;
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
	} qentry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== rtl/core/bmsi_queue.sv =====
// ----------------------------------------------------------------------------
// bmsi_queue
// Short request queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module bmsi_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  bmsi_pkg::qentry_t   wr_entry,
	input  logic                rd_en,
	output bmsi_pkg::qentry_t   rd_entry,
	output bmsi_pkg::qstat_t    stat
);

	bmsi_pkg::qentry_t                 entry_q [bmsi_pkg::QDEPTH];
	logic [bmsi_pkg::QPTR_W-1:0]       wptr_q;
	logic [bmsi_pkg::QPTR_W-1:0]       rptr_q;
	logic [bmsi_pkg::QCNT_W-1:0]       count_q;
	logic                              do_wr;
	logic                              do_rd;

	// status and qualified strobes
	assign stat.full  = (count_q == bmsi_pkg::QCNT_W'(bmsi_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_entry   = entry_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// fill count stays within depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bmsi_pkg::QCNT_W'(bmsi_pkg::QDEPTH))
		else $error("queue fill count beyond depth");

endmodule

// ===== rtl/core/bmsi_front.sv =====
// ----------------------------------------------------------------------------
// bmsi_front
// Accepts bus requests and classifies them by type and address range.
// ----------------------------------------------------------------------------
module bmsi_front (
	input  logic               push,
	input  bmsi_pkg::item_t    item,
	output logic               full,
	input  bmsi_pkg::qstat_t   q_stat,
	output logic               q_wr,
	output bmsi_pkg::qentry_t  q_entry
);

	bmsi_pkg::op_t op;

	// request class from type and address
	always_comb begin
		op = bmsi_pkg::OP_NONE;
		case (item.req_type)
			bmsi_pkg::REQ_CPU_RD, bmsi_pkg::REQ_CPU_WR: begin
				if (item.address[15]) begin
					op = (item.req_type == bmsi_pkg::REQ_CPU_WR) ?
						bmsi_pkg::OP_REG : bmsi_pkg::OP_PRG;
				end else if (item.address >= bmsi_pkg::ADDR_RAM_BASE) begin
					op = bmsi_pkg::OP_RAM;
				end
			end
			bmsi_pkg::REQ_PPU_RD, bmsi_pkg::REQ_PPU_WR: begin
				op = bmsi_pkg::OP_CHR;
			end
			bmsi_pkg::REQ_A12: begin
				op = bmsi_pkg::OP_A12;
			end
			default: begin
				op = bmsi_pkg::OP_NONE;
			end
		endcase
	end

	// queue write side
	assign full          = q_stat.full;
	assign q_wr          = push && !q_stat.full;
	assign q_entry.op    = op;
	assign q_entry.wr    = (item.req_type == bmsi_pkg::REQ_CPU_WR) ||
	                       (item.req_type == bmsi_pkg::REQ_PPU_WR);
	assign q_entry.addr  = item.address;
	assign q_entry.data  = item.write_data;

endmodule

// ===== rtl/core/bmsi_back.sv =====
// ----------------------------------------------------------------------------
// bmsi_back
// Executes classified requests: mapper state, bank translation with an
// iterative modulo unit, scanline counter, and the result register.
// ----------------------------------------------------------------------------
module bmsi_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bmsi_pkg::qstat_t                    q_stat,
	input  bmsi_pkg::qentry_t                   q_entry,
	output logic                                q_pop,
	input  logic                                cfg_write,
	input  logic [bmsi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bmsi_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                empty,
	input  logic                                pop,
	output bmsi_pkg::result_t                   result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t              state_q;

	// configuration
	logic [6:0]          prg_banks_q;
	logic [8:0]          chr_banks_q;
	logic                chr_ram_q;
	logic                four_screen_q;

	// mapper state
	logic [7:0]          bank_select_q;
	logic [7:0]          bank_regs_q [8];
	logic [7:0]          irq_reload_q;
	logic [7:0]          irq_count_q;
	logic                reload_pend_q;
	logic                irq_en_q;
	logic                irq_pend_q;
	logic                ram_en_q;
	logic                mirror_h_q;

	// work and result registers
	logic [7:0]          dvd_q;
	logic [8:0]          div_q;
	logic [8:0]          rem_q;
	logic [bmsi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [12:0]         off_q;
	logic                is_chr_q;
	logic [1:0]          res_target_q;
	logic [18:0]         res_addr_q;
	logic                res_wr_q;
	bmsi_pkg::result_t   out_q;
	logic                out_valid_q;

	// combinational helpers
	logic [8:0]          prg_n;
	logic [8:0]          chr_n;
	logic [7:0]          prg_last;
	logic [7:0]          prg_bank;
	logic [12:0]         chr_a;
	logic [2:0]          chr_idx;
	logic [7:0]          chr_bank;
	logic [7:0]          cnt_next;
	logic [8:0]          trial;
	logic [8:0]          rem_next;
	logic                slot_free;
	logic                take;
	logic [1:0]          mirror_mode;

	// clamped bank counts
	always_comb begin
		prg_n = {2'b00, prg_banks_q};
		if (prg_n < 9'(bmsi_pkg::MIN_PRG_BANKS)) begin
			prg_n = 9'(bmsi_pkg::MIN_PRG_BANKS);
		end
		if (prg_n > 9'(bmsi_pkg::MAX_PRG_BANKS)) begin
			prg_n = 9'(bmsi_pkg::MAX_PRG_BANKS);
		end
		chr_n = chr_banks_q;
		if (chr_n < 9'(bmsi_pkg::MIN_CHR_BANKS)) begin
			chr_n = 9'(bmsi_pkg::MIN_CHR_BANKS);
		end
		if (chr_n > 9'(bmsi_pkg::MAX_CHR_BANKS)) begin
			chr_n = 9'(bmsi_pkg::MAX_CHR_BANKS);
		end
	end

	// program bank before reduction
	assign prg_last = 8'(prg_n - 9'd1);
	always_comb begin
		case (q_entry.addr[14:13])
			2'd0:    prg_bank = bank_select_q[6] ? prg_last - 8'd1 : bank_regs_q[6];
			2'd1:    prg_bank = bank_regs_q[7];
			2'd2:    prg_bank = bank_select_q[6] ? bank_regs_q[6] : prg_last - 8'd1;
			default: prg_bank = prg_last;
		endcase
	end

	// pattern bank before reduction, halves swapped by bank select bit 7
	assign chr_a   = q_entry.addr[12:0] ^ {bank_select_q[7], 12'h000};
	assign chr_idx = 3'd2 + {1'b0, chr_a[11:10]};
	always_comb begin
		if (!chr_a[12]) begin
			chr_bank = chr_a[11] ? {bank_regs_q[1][7:1], chr_a[10]}
			                     : {bank_regs_q[0][7:1], chr_a[10]};
		end else begin
			chr_bank = bank_regs_q[chr_idx];
		end
	end

	// scanline counter next value
	assign cnt_next = ((irq_count_q == 8'd0) || reload_pend_q) ?
		irq_reload_q : irq_count_q - 8'd1;

	// one restoring step of the modulo unit
	assign trial    = {rem_q[7:0], dvd_q[7]};
	assign rem_next = (trial >= div_q) ? trial - div_q : trial;

	// handshake
	assign slot_free   = !out_valid_q || pop;
	assign take        = (state_q == ST_IDLE) && !q_stat.empty;
	assign q_pop       = take;
	assign empty       = !out_valid_q;
	assign result      = out_q;
	assign mirror_mode = four_screen_q ? bmsi_pkg::MIRROR_FOUR :
		(mirror_h_q ? bmsi_pkg::MIRROR_HORZ : bmsi_pkg::MIRROR_VERT);

	// sequencer, mapper state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prg_banks_q   <= 7'(bmsi_pkg::MAX_PRG_BANKS);
			chr_banks_q   <= 9'(bmsi_pkg::MIN_CHR_BANKS);
			chr_ram_q     <= 1'b0;
			four_screen_q <= 1'b0;
			bank_select_q <= '0;
			for (int i = 0; i < 8; i++) begin
				bank_regs_q[i] <= '0;
			end
			irq_reload_q  <= '0;
			irq_count_q   <= '0;
			reload_pend_q <= 1'b0;
			irq_en_q      <= 1'b0;
			irq_pend_q    <= 1'b0;
			ram_en_q      <= 1'b1;
			mirror_h_q    <= 1'b0;
			dvd_q         <= '0;
			div_q         <= 9'd1;
			rem_q         <= '0;
			cnt_q         <= '0;
			off_q         <= '0;
			is_chr_q      <= 1'b0;
			res_target_q  <= bmsi_pkg::TGT_NONE;
			res_addr_q    <= '0;
			res_wr_q      <= 1'b0;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_write) begin
				case (cfg_index)
					bmsi_pkg::CFG_PRG_BANKS:   prg_banks_q   <= cfg_data[6:0];
					bmsi_pkg::CFG_CHR_BANKS:   chr_banks_q   <= cfg_data;
					bmsi_pkg::CFG_CHR_IS_RAM:  chr_ram_q     <= cfg_data[0];
					bmsi_pkg::CFG_FOUR_SCREEN: four_screen_q <= cfg_data[0];
					bmsi_pkg::CFG_INIT_MIRROR: mirror_h_q    <= cfg_data[0];
					default: ;
				endcase
			end

			// result loaded by the sequencer or taken by the consumer
			if ((state_q == ST_FIN) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (take) begin
						rem_q <= '0;
						cnt_q <= '0;
						off_q <= q_entry.addr[12:0];
						// result fields and next step by request class
						case (q_entry.op)
							bmsi_pkg::OP_PRG: begin
								res_target_q <= bmsi_pkg::TGT_PRG_ROM;
								res_addr_q   <= '0;
								res_wr_q     <= 1'b0;
								dvd_q        <= prg_bank;
								div_q        <= prg_n;
								is_chr_q     <= 1'b0;
								state_q      <= ST_DIV;
							end
							bmsi_pkg::OP_CHR: begin
								res_target_q <= bmsi_pkg::TGT_CHR;
								res_addr_q   <= '0;
								res_wr_q     <= q_entry.wr && chr_ram_q;
								dvd_q        <= chr_bank;
								div_q        <= chr_n;
								is_chr_q     <= 1'b1;
								state_q      <= ST_DIV;
							end
							bmsi_pkg::OP_RAM: begin
								res_target_q <= ram_en_q ? bmsi_pkg::TGT_PRG_RAM
								                         : bmsi_pkg::TGT_NONE;
								res_addr_q   <= ram_en_q ? {6'd0, q_entry.addr[12:0]} : 19'd0;
								res_wr_q     <= ram_en_q && q_entry.wr;
								state_q      <= ST_FIN;
							end
							default: begin
								res_target_q <= bmsi_pkg::TGT_NONE;
								res_addr_q   <= '0;
								res_wr_q     <= 1'b0;
								state_q      <= ST_FIN;
							end
						endcase
						// mapper register writes
						if (q_entry.op == bmsi_pkg::OP_REG) begin
							case (q_entry.addr[14:13])
								bmsi_pkg::REG_BANK: begin
									if (!q_entry.addr[0]) begin
										bank_select_q <= q_entry.data;
									end else begin
										bank_regs_q[bank_select_q[2:0]] <= q_entry.data;
									end
								end
								bmsi_pkg::REG_MIRROR: begin
									if (!q_entry.addr[0]) begin
										if (!four_screen_q) begin
											mirror_h_q <= q_entry.data[0];
										end
									end else begin
										ram_en_q <= q_entry.data[7];
									end
								end
								bmsi_pkg::REG_LATCH: begin
									if (!q_entry.addr[0]) begin
										irq_reload_q <= q_entry.data;
									end else begin
										irq_count_q   <= '0;
										reload_pend_q <= 1'b1;
									end
								end
								default: begin
									if (!q_entry.addr[0]) begin
										irq_en_q   <= 1'b0;
										irq_pend_q <= 1'b0;
									end else begin
										irq_en_q <= 1'b1;
									end
								end
							endcase
						end
						// scanline counter on an address line 12 rise
						if (q_entry.op == bmsi_pkg::OP_A12) begin
							irq_count_q   <= cnt_next;
							reload_pend_q <= 1'b0;
							if ((cnt_next == 8'd0) && irq_en_q) begin
								irq_pend_q <= 1'b1;
							end
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					dvd_q <= {dvd_q[6:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == bmsi_pkg::DIV_CNT_W'(bmsi_pkg::DIV_STEPS - 1)) begin
						res_addr_q <= is_chr_q ? {1'b0, rem_next[7:0], off_q[9:0]}
						                       : {rem_next[5:0], off_q};
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						out_q.target      <= res_target_q;
						out_q.mem_address <= res_addr_q;
						out_q.mem_write   <= res_wr_q;
						out_q.irq         <= irq_pend_q;
						out_q.mirror_mode <= mirror_mode;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// partial remainder stays below the divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_q))
		else $error("modulo remainder not below bank count");

	// a taken request always passes through execution before the next one
	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q != ST_IDLE))
		else $error("request taken without leaving idle");

	// a result with no target carries a zero offset and no write
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.target == bmsi_pkg::TGT_NONE)) |->
		((out_q.mem_address == '0) && !out_q.mem_write))
		else $error("untargeted result with offset or write");

endmodule

// ===== rtl/core/bank_mapper_with_scanline_irq_unit.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_unit
// Cartridge bank mapper with scanline counter interrupt.
// ----------------------------------------------------------------------------
// Each request (cpu read or write, ppu pattern read or write, or a rise on
// address line 12) yields one result: target memory, byte offset, write
// enable, interrupt level and mirroring mode. Requests are classified on entry
// and held in a four-deep queue; the back end executes one request at a time.
// Program and pattern accesses pass through the 8-step modulo unit that
// reduces the bank number by the configured bank count; all other requests
// skip it. A finished result waits in the output register while further
// requests keep filling the queue. Configuration writes take effect at once
// and are meant for an idle block.
module bank_mapper_with_scanline_irq_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  bmsi_pkg::item_t                     item,
	output logic                                empty,
	input  logic                                pop,
	output bmsi_pkg::result_t                   result,
	input  logic                                cfg_write,
	input  logic [bmsi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bmsi_pkg::CFG_DATA_W-1:0]     cfg_data
);

	bmsi_pkg::qstat_t   q_stat;
	bmsi_pkg::qentry_t  q_wr_entry;
	bmsi_pkg::qentry_t  q_rd_entry;
	logic               q_wr;
	logic               q_pop;

	// request intake and classification
	bmsi_front u_front (
		.push    (push),
		.item    (item),
		.full    (full),
		.q_stat  (q_stat),
		.q_wr    (q_wr),
		.q_entry (q_wr_entry)
	);

	// decoupling queue
	bmsi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_entry (q_wr_entry),
		.rd_en    (q_pop),
		.rd_entry (q_rd_entry),
		.stat     (q_stat)
	);

	// execution and results
	bmsi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_entry   (q_rd_entry),
		.q_pop     (q_pop),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
